FILE: hw/rtl/gbe_pkg.sv
// Shared types and constants for the gap buffer engine.
// Holds the request and result item types and the controller/datapath link types.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gbe_pkg;

  localparam int FIELD_W = 13;

  localparam logic [2:0] MODE_INSERT   = 3'd0;
  localparam logic [2:0] MODE_DEL_BACK = 3'd1;
  localparam logic [2:0] MODE_DEL_FWD  = 3'd2;
  localparam logic [2:0] MODE_MOVE     = 3'd3;
  localparam logic [2:0] MODE_READ     = 3'd4;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [2:0]         mode;
    logic [7:0]         char_in;
    logic [FIELD_W-1:0] count;
    logic [FIELD_W-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         char_out;
    logic               status;
    logic [FIELD_W-1:0] text_length;
    logic [FIELD_W-1:0] cursor;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic copy;
    logic rd_done;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic go_copy;
    logic go_read;
    logic copy_done;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gbe_ctrl.sv
// Controller state machine of the gap buffer engine.
// Sequences each request through the datapath and owns the handshakes.
// Depends on gbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbe_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output gbe_pkg::dp_cmd_t      cmd,
  input  wire gbe_pkg::dp_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_COPY,
    S_RDWAIT,
    S_FIN
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  assign cmd.capture = accept;
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.copy    = (state_r == S_COPY);
  assign cmd.rd_done = (state_r == S_RDWAIT);
  assign cmd.load    = (state_r == S_FIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (sts.go_copy) begin
            state_r <= S_COPY;
          end else if (sts.go_read) begin
            state_r <= S_RDWAIT;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_COPY: begin
          if (sts.copy_done) begin
            state_r <= S_FIN;
          end
        end
        S_RDWAIT: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (state_r == S_FIN) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // A request is only taken once the result register is free, so it stays free while busy.
  a_busy_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r)
    else $error("result pending while a request is in progress");

  a_fin_presents: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> out_valid_r)
    else $error("finished request did not present a result");

endmodule

`default_nettype wire

FILE: hw/rtl/gbe_dp.sv
// Datapath of the gap buffer engine: text memory, gap pointers, copy unit, result register.
// Executes the commands of the controller and reports status back to it.
// Depends on gbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbe_dp #(
  parameter int CAPACITY = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gbe_pkg::in_item_t in_data,
  input  wire gbe_pkg::dp_cmd_t  cmd,
  output gbe_pkg::dp_sts_t       sts,
  output gbe_pkg::out_item_t     out_data
);

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int FW = gbe_pkg::FIELD_W;
  localparam int CW = (PW > FW) ? PW : FW;
  localparam logic [PW-1:0] CAP = PW'(CAPACITY);

  logic [7:0] mem [CAPACITY];

  gbe_pkg::in_item_t  op_r;
  gbe_pkg::out_item_t out_r;

  logic [PW-1:0] gs_r, gs_nxt;
  logic [PW-1:0] ge_r, ge_nxt;
  logic [PW-1:0] src_r, src_nxt;
  logic [PW-1:0] dst_r, dst_nxt;
  logic [PW-1:0] left_r, left_nxt;
  logic [PW-1:0] pdst_r;
  logic          dir_r, dir_nxt;
  logic          pvalid_r, pvalid_nxt;
  logic [7:0]    rdata_r;
  logic [7:0]    res_char_r, res_char_nxt;
  logic          res_status_r, res_status_nxt;

  logic [PW-1:0] len, avail, tgt, rd_phys, back_cnt, fwd_cnt;
  logic [CW-1:0] gs_cw, len_cw, count_cw, pos_cw, avail_cw, tgt_cw;
  logic          rd_en, wr_en;
  logic [PW-1:0] rd_addr, wr_addr;
  logic [7:0]    wr_data;

  assign len      = CAP - (ge_r - gs_r);
  assign avail    = CAP - ge_r;
  assign gs_cw    = CW'(gs_r);
  assign len_cw   = CW'(len);
  assign avail_cw = CW'(avail);
  assign count_cw = CW'(op_r.count);
  assign pos_cw   = CW'(op_r.position);
  assign tgt_cw   = (pos_cw > len_cw) ? len_cw : pos_cw;
  assign tgt      = tgt_cw[PW-1:0];
  assign back_cnt = (count_cw > gs_cw) ? gs_r : count_cw[PW-1:0];
  assign fwd_cnt  = (count_cw > avail_cw) ? avail : count_cw[PW-1:0];
  assign rd_phys  = (pos_cw < gs_cw) ? pos_cw[PW-1:0] : ge_r + (pos_cw[PW-1:0] - gs_r);

  assign sts.go_copy   = (op_r.mode == gbe_pkg::MODE_MOVE) && (tgt != gs_r);
  assign sts.go_read   = (op_r.mode == gbe_pkg::MODE_READ) && (pos_cw < len_cw);
  assign sts.copy_done = (left_r == '0) && !pvalid_r;

  always_comb begin
    gs_nxt         = gs_r;
    ge_nxt         = ge_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    left_nxt       = left_r;
    dir_nxt        = dir_r;
    pvalid_nxt     = 1'b0;
    res_char_nxt   = res_char_r;
    res_status_nxt = res_status_r;
    rd_en          = 1'b0;
    rd_addr        = src_r;
    wr_en          = pvalid_r;
    wr_addr        = pdst_r;
    wr_data        = rdata_r;
    if (cmd.capture) begin
      res_char_nxt   = '0;
      res_status_nxt = gbe_pkg::STATUS_DONE;
    end
    if (cmd.exec) begin
      unique case (op_r.mode)
        gbe_pkg::MODE_INSERT: begin
          if (gs_r < ge_r) begin
            wr_en   = 1'b1;
            wr_addr = gs_r;
            wr_data = op_r.char_in;
            gs_nxt  = gs_r + PW'(1);
          end else begin
            res_status_nxt = gbe_pkg::STATUS_FULL;
          end
        end
        gbe_pkg::MODE_DEL_BACK: begin
          gs_nxt = gs_r - back_cnt;
        end
        gbe_pkg::MODE_DEL_FWD: begin
          ge_nxt = ge_r + fwd_cnt;
        end
        gbe_pkg::MODE_MOVE: begin
          if (sts.go_copy) begin
            gs_nxt = tgt;
            if (tgt < gs_r) begin
              left_nxt = gs_r - tgt;
              src_nxt  = gs_r - PW'(1);
              dst_nxt  = ge_r - PW'(1);
              dir_nxt  = 1'b0;
              ge_nxt   = ge_r - (gs_r - tgt);
            end else begin
              left_nxt = tgt - gs_r;
              src_nxt  = ge_r;
              dst_nxt  = gs_r;
              dir_nxt  = 1'b1;
              ge_nxt   = ge_r + (tgt - gs_r);
            end
          end
        end
        gbe_pkg::MODE_READ: begin
          if (sts.go_read) begin
            rd_en   = 1'b1;
            rd_addr = rd_phys;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.copy && (left_r != '0)) begin
      rd_en      = 1'b1;
      rd_addr    = src_r;
      pvalid_nxt = 1'b1;
      left_nxt   = left_r - PW'(1);
      src_nxt    = dir_r ? src_r + PW'(1) : src_r - PW'(1);
      dst_nxt    = dir_r ? dst_r + PW'(1) : dst_r - PW'(1);
    end
    if (cmd.rd_done) begin
      res_char_nxt = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r     <= '0;
      ge_r     <= CAP;
      left_r   <= '0;
      pvalid_r <= 1'b0;
    end else begin
      gs_r     <= gs_nxt;
      ge_r     <= ge_nxt;
      left_r   <= left_nxt;
      pvalid_r <= pvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_data;
    end
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    dir_r        <= dir_nxt;
    pdst_r       <= dst_r;
    res_char_r   <= res_char_nxt;
    res_status_r <= res_status_nxt;
    if (cmd.load) begin
      out_r.char_out    <= res_char_r;
      out_r.status      <= res_status_r;
      out_r.text_length <= len_cw[FW-1:0];
      out_r.cursor      <= gs_cw[FW-1:0];
    end
  end

  assign out_data = out_r;

  a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
    gs_r <= ge_r)
    else $error("gap start passed gap end");

  a_gap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ge_r <= CAP)
    else $error("gap end beyond capacity");

  a_copy_addr: assert property (@(posedge clk) disable iff (!rst_n)
    pvalid_r |-> (pdst_r < CAP))
    else $error("copy write outside the text memory");

endmodule

`default_nettype wire

FILE: hw/rtl/gap_buffer_engine.sv
// Gap buffer engine top level: a fixed-capacity text gap buffer.
// Joins the controller (gbe_ctrl) and the datapath (gbe_dp); types from gbe_pkg.
//
// Usage: each request on in_data (valid/ready) is one edit operation chosen by
// mode: insert a byte at the cursor, delete before or after the cursor, move the
// cursor, or read the byte at a text position. Each request yields exactly one
// result on out_data (valid/ready) with the byte read, a full-buffer status,
// the text length and the cursor.
// From acceptance to out_valid, insert, delete, unused modes, a move that stays at the
// cursor and a read beyond the text pass the execute and finish states; a read in the
// text adds a read-wait state; a move of n bytes across the gap adds a copy state.
// The copy moves one byte per cycle through the text memory's single read and write ports.
// One request is worked on at a time; a new one is taken at the earliest in the cycle
// after the previous result is loaded.
// The result sits in an output register; a stalled receiver holds it there, and
// the next request is taken as soon as that result is being taken.
// Reset empties the buffer (cursor 0, gap spanning the whole memory) and clears
// all pending work; the text memory itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module gap_buffer_engine #(
  parameter int CAPACITY = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire gbe_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output gbe_pkg::out_item_t      out_data
);

  gbe_pkg::dp_cmd_t cmd;
  gbe_pkg::dp_sts_t sts;

  gbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  gbe_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
